FILE: rtl/sbf_pkg.sv
// shared types and constants of the separable bilateral filter
package sbf_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 12;
  localparam int COL_W = 11;
  localparam int WGT_W = 11;
  localparam int IDX_W = 8;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W = 2 * WGT_W;
  localparam int RANGE_DEPTH = 256;
  localparam int WIDTH_CAP = 2048;
  localparam int HEIGHT_CAP = 4096;

  localparam logic [1:0] OP_PIXEL   = 2'd0;
  localparam logic [1:0] OP_RANGE   = 2'd1;
  localparam logic [1:0] OP_SPATIAL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic             frame_start;
    logic [PIX_W-1:0] pixel;
    logic [IDX_W-1:0] table_index;
    logic [WGT_W-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [PIX_W-1:0] out_value;
    logic             last_of_run;
  } out_item_t;

endpackage

FILE: rtl/sbf_stream_if.sv
// valid/ready stream channel carrying one payload item
interface sbf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/separable_bilateral_filter.sv
// top level: position tracking, line stores and the pass sequencer
// usage
//   in_i takes table writes and pixels in raster order; out_o returns results.
//   a table write yields nothing.
//   a border pixel left of column 2r goes from the position state straight
//   to the pass-through emit state, which writes it into the result queue.
//   a pixel at column 2r or beyond runs a horizontal pass, and one that is
//   also at row 2r or beyond then runs the vertical pass; a border pixel
//   emits its pass-through after these passes.
//   each pass runs through the shared tap unit, which takes one tap per cycle
//   through lookup, multiply and accumulate, and through the 8-step divider.
//   in_i is ready only while the sequencer is idle.
//   an interior result comes out r rows and r columns after its source pixel,
//   ahead of the pass-through of the same input; last_of_run flags the last.
//   a two-entry result queue lets a new item be taken while results wait;
//   a stalled receiver holds the sequencer only when the queue is full.
//   reset clears the position to row 0, column 0 and loads the default
//   registers; weight tables and line stores hold nothing until written.
//   configure through cfg_we_i only while no item is in flight.
module separable_bilateral_filter
  import sbf_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sbf_stream_if.sink           in_i,
  sbf_stream_if.source         out_o
);
  localparam int HOR_ROWS = 2 * MAX_RADIUS + 1;
  localparam int MOD_W    = $clog2(HOR_ROWS);
  localparam int TAP_W    = $clog2(HOR_ROWS);
  localparam int SP_W     = $clog2(MAX_RADIUS + 1);
  localparam int COL_AW   = $clog2(MAX_WIDTH);
  localparam int HOR_AW   = $clog2(HOR_ROWS * MAX_WIDTH);
  localparam int NORM_W   = PROD_W + $clog2(HOR_ROWS);
  localparam int SUM_W    = NORM_W + PIX_W;
  localparam int NUM_W    = SUM_W + 1;
  localparam int W_CAP    = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POS   = 4'd1;
  localparam logic [3:0] S_HCEN  = 4'd2;
  localparam logic [3:0] S_VCEN  = 4'd3;
  localparam logic [3:0] S_CW    = 4'd4;
  localparam logic [3:0] S_TAP   = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_WRH   = 4'd8;
  localparam logic [3:0] S_EMITF = 4'd9;
  localparam logic [3:0] S_EMITP = 4'd10;

  logic [3:0] state_q, state_d;

  // configuration
  logic [11:0] cfg_w_q;
  logic [12:0] cfg_h_q;
  logic [3:0]  cfg_r_q;
  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic [3:0]  r_eff;
  logic [4:0]  r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 12'd2048;
      cfg_h_q <= 13'd1024;
      cfg_r_q <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  cfg_w_q <= cfg_data_i[11:0];
        REG_HEIGHT: cfg_h_q <= cfg_data_i;
        REG_RADIUS: cfg_r_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (cfg_w_q == '0) ? 12'd1 :
                 (cfg_w_q > 12'(W_CAP)) ? 12'(W_CAP) : cfg_w_q;
  assign h_eff = (cfg_h_q == '0) ? 13'd1 :
                 (cfg_h_q > 13'(HEIGHT_CAP)) ? 13'(HEIGHT_CAP) : cfg_h_q;
  assign r_eff = (cfg_r_q == '0) ? 4'd1 :
                 (5'(cfg_r_q) > 5'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : cfg_r_q;
  assign r2    = {r_eff, 1'b0};

  // position and current item
  logic [ROW_W-1:0] pos_row_q, cur_row_q;
  logic [COL_W-1:0] pos_col_q, cur_col_q;
  logic [MOD_W-1:0] pos_mod_q, cur_mod_q;
  logic [PIX_W-1:0] pix_q;
  logic             vert_q, pass_q, vsel_q;

  in_item_t         item;
  logic             accept, acc_pix;
  logic [12:0]      row_a, row_b;
  logic [11:0]      col_a, col_b;
  logic [MOD_W-1:0] mod_a, mod_b, mod_c, mod_inc_a, mod_inc_cur;
  logic [12:0]      row_c;

  assign item     = in_i.payload;
  assign in_i.ready = state_q == S_IDLE;
  assign accept   = in_i.valid & in_i.ready;
  assign acc_pix  = accept & (item.op == OP_PIXEL);

  assign row_a = item.frame_start ? '0 : 13'(pos_row_q);
  assign col_a = item.frame_start ? '0 : 12'(pos_col_q);
  assign mod_a = item.frame_start ? '0 : pos_mod_q;
  assign mod_inc_a = (mod_a == MOD_W'(HOR_ROWS - 1)) ? '0 : mod_a + 1'b1;

  always_comb begin
    row_b = row_a;
    col_b = col_a;
    mod_b = mod_a;
    if (col_a >= w_eff) begin
      col_b = '0;
      row_b = row_a + 1'b1;
      mod_b = mod_inc_a;
    end
    row_c = row_b;
    mod_c = mod_b;
    if (row_b >= h_eff) begin
      row_c = '0;
      mod_c = '0;
    end
  end

  assign mod_inc_cur = (cur_mod_q == MOD_W'(HOR_ROWS - 1)) ? '0 : cur_mod_q + 1'b1;

  // next position after the current pixel
  logic [11:0] col_n;
  logic [12:0] row_n;
  assign col_n = 12'(cur_col_q) + 1'b1;
  assign row_n = 13'(cur_row_q) + 1'b1;

  // sequencer datapath
  logic [TAP_W-1:0] t_q;
  logic [TAP_W:0]   k_full;
  logic             tv_q;
  logic [SP_W-1:0]  tk_q;
  logic [PIX_W-1:0] cen_q, res_q, rd_data;
  logic [MOD_W-1:0] ridx_q;
  logic [MOD_W:0]   vstart_raw, vcen_raw;
  logic [MOD_W-1:0] vstart, vcen, ridx_inc;
  logic [COL_W-1:0] x_col;
  logic [11:0]      htap_col;

  assign x_col    = cur_col_q - COL_W'(r_eff);
  assign htap_col = 12'(cur_col_q) - 12'(r2) + 12'(t_q);
  assign k_full   = ((TAP_W+1)'(t_q) >= (TAP_W+1)'(r_eff)) ?
                    (TAP_W+1)'(t_q) - (TAP_W+1)'(r_eff) :
                    (TAP_W+1)'(r_eff) - (TAP_W+1)'(t_q);

  assign vstart_raw = (MOD_W+1)'(cur_mod_q) + (MOD_W+1)'(HOR_ROWS) - (MOD_W+1)'(r2);
  assign vcen_raw   = (MOD_W+1)'(cur_mod_q) + (MOD_W+1)'(HOR_ROWS) - (MOD_W+1)'(r_eff);
  assign vstart = (vstart_raw >= (MOD_W+1)'(HOR_ROWS)) ?
                  MOD_W'(vstart_raw - (MOD_W+1)'(HOR_ROWS)) : MOD_W'(vstart_raw);
  assign vcen   = (vcen_raw >= (MOD_W+1)'(HOR_ROWS)) ?
                  MOD_W'(vcen_raw - (MOD_W+1)'(HOR_ROWS)) : MOD_W'(vcen_raw);
  assign ridx_inc = (ridx_q == MOD_W'(HOR_ROWS - 1)) ? '0 : ridx_q + 1'b1;

  // line stores
  logic [PIX_W-1:0]  src_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  hor_mem [HOR_ROWS*MAX_WIDTH];
  logic [PIX_W-1:0]  src_rd_q, hor_rd_q;
  logic [COL_AW-1:0] src_raddr;
  logic [HOR_AW-1:0] hor_raddr, hor_waddr;
  logic [MOD_W-1:0]  hrow_sel;

  assign src_raddr = (state_q == S_HCEN) ? COL_AW'(x_col) : COL_AW'(htap_col);
  assign hrow_sel  = (state_q == S_VCEN) ? vcen : ridx_q;
  assign hor_raddr = HOR_AW'(hrow_sel) * HOR_AW'(MAX_WIDTH) + HOR_AW'(x_col);
  assign hor_waddr = HOR_AW'(cur_mod_q) * HOR_AW'(MAX_WIDTH) + HOR_AW'(x_col);
  assign rd_data   = vsel_q ? hor_rd_q : src_rd_q;

  always_ff @(posedge clk_i) begin
    if (acc_pix) begin
      src_mem[COL_AW'(col_b)] <= item.pixel;
    end
    src_rd_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRH) begin
      hor_mem[hor_waddr] <= res_q;
    end
    hor_rd_q <= hor_mem[hor_raddr];
  end

  // shared tap unit and divider
  logic [NORM_W-1:0] norm;
  logic [SUM_W-1:0]  sum;
  logic              wsum_busy, div_start, div_done;
  logic [PIX_W-1:0]  quo;

  assign div_start = (state_q == S_DRAIN) & ~tv_q & ~wsum_busy;

  sbf_wsum #(
    .MAX_RADIUS (MAX_RADIUS),
    .NORM_W     (NORM_W),
    .SUM_W      (SUM_W)
  ) u_wsum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rng_we_i    (accept & (item.op == OP_RANGE)),
    .spt_we_i    (accept & (item.op == OP_SPATIAL) &
                  (9'(item.table_index) <= 9'(MAX_RADIUS))),
    .wr_idx_i    (item.table_index),
    .wr_val_i    (item.table_value),
    .clear_i     (state_q == S_CW),
    .cen_i       (cen_q),
    .tap_valid_i (tv_q),
    .tap_v_i     (rd_data),
    .tap_k_i     (tk_q),
    .norm_o      (norm),
    .sum_o       (sum),
    .busy_o      (wsum_busy)
  );

  sbf_div #(
    .NUM_W (NUM_W),
    .DEN_W (NORM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NUM_W'(sum) + NUM_W'(norm >> 1)),
    .den_i   (norm),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // result queue
  logic      fifo_full, push;
  out_item_t push_data;

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (state_q == S_EMITF) begin
      push                = ~fifo_full;
      push_data.out_row   = cur_row_q - ROW_W'(r_eff);
      push_data.out_col   = x_col;
      push_data.out_value = res_q;
      push_data.last_of_run = ~pass_q;
    end else if (state_q == S_EMITP) begin
      push                = ~fifo_full;
      push_data.out_row   = cur_row_q;
      push_data.out_col   = cur_col_q;
      push_data.out_value = pix_q;
      push_data.last_of_run = 1'b1;
    end
  end

  sbf_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (fifo_full),
    .out_o  (out_o)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (acc_pix) state_d = S_POS;
      S_POS: begin
        if (12'(cur_col_q) >= 12'(r2)) begin
          state_d = S_HCEN;
        end else if ((cur_row_q < ROW_W'(r_eff)) ||
                     (13'(cur_row_q) + 13'(r_eff) >= h_eff) ||
                     (cur_col_q < COL_W'(r_eff)) ||
                     (12'(cur_col_q) + 12'(r_eff) >= w_eff)) begin
          state_d = S_EMITP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_HCEN:  state_d = S_CW;
      S_VCEN:  state_d = S_CW;
      S_CW:    state_d = S_TAP;
      S_TAP:   if (5'(t_q) == r2) state_d = S_DRAIN;
      S_DRAIN: if (div_start) state_d = S_DIV;
      S_DIV: begin
        if (div_done) state_d = vsel_q ? S_EMITF : S_WRH;
      end
      S_WRH: begin
        if (vert_q) state_d = S_VCEN;
        else if (pass_q) state_d = S_EMITP;
        else state_d = S_IDLE;
      end
      S_EMITF: if (!fifo_full) state_d = pass_q ? S_EMITP : S_IDLE;
      S_EMITP: if (!fifo_full) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_row_q <= '0;
      pos_col_q <= '0;
      pos_mod_q <= '0;
      tv_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      tv_q    <= state_q == S_TAP;
      if (state_q == S_POS) begin
        if (col_n >= w_eff) begin
          pos_col_q <= '0;
          if (row_n >= h_eff) begin
            pos_row_q <= '0;
            pos_mod_q <= '0;
          end else begin
            pos_row_q <= row_n[ROW_W-1:0];
            pos_mod_q <= mod_inc_cur;
          end
        end else begin
          pos_col_q <= col_n[COL_W-1:0];
          pos_row_q <= cur_row_q;
          pos_mod_q <= cur_mod_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tk_q <= SP_W'(k_full);
    if (acc_pix) begin
      cur_row_q <= row_c[ROW_W-1:0];
      cur_col_q <= col_b[COL_W-1:0];
      cur_mod_q <= mod_c;
      pix_q     <= item.pixel;
    end
    if (state_q == S_POS) begin
      vert_q <= (12'(cur_col_q) >= 12'(r2)) && (13'(cur_row_q) >= 13'(r2));
      pass_q <= (cur_row_q < ROW_W'(r_eff)) ||
                (13'(cur_row_q) + 13'(r_eff) >= h_eff) ||
                (cur_col_q < COL_W'(r_eff)) ||
                (12'(cur_col_q) + 12'(r_eff) >= w_eff);
    end
    if (state_q == S_HCEN) begin
      vsel_q <= 1'b0;
    end
    if (state_q == S_VCEN) begin
      vsel_q <= 1'b1;
      ridx_q <= vstart;
    end
    if (state_q == S_CW) begin
      cen_q <= rd_data;
      t_q   <= '0;
    end
    if (state_q == S_TAP) begin
      t_q    <= t_q + 1'b1;
      ridx_q <= ridx_inc;
    end
    if (state_q == S_DIV && div_done) begin
      res_q <= (norm == '0) ? cen_q : quo;
    end
  end
endmodule

FILE: rtl/sbf_div.sv
// iterative restoring divider producing an 8-bit quotient, one bit per cycle
module sbf_div
  import sbf_pkg::*;
#(
  parameter int NUM_W = 36,
  parameter int DEN_W = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [PIX_W-1:0] quo_o
);
  localparam int STEP_W = $clog2(PIX_W);

  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q;
  logic [PIX_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q;
  logic              run_q, done_q;
  logic [NUM_W-1:0]  trial;
  logic              fits;

  // the caller guarantees the quotient stays below 256
  assign trial = NUM_W'(den_q) << (STEP_W'(PIX_W - 1) - step_q);
  assign fits  = rem_q >= trial;
  assign rem_d = fits ? rem_q - trial : rem_q;
  assign quo_d = {quo_q[PIX_W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(PIX_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

FILE: rtl/sbf_wsum.sv
// weight tables and the shared tap unit: weight lookup, multiply, accumulate
module sbf_wsum
  import sbf_pkg::*;
#(
  parameter int MAX_RADIUS = 8,
  parameter int NORM_W = 27,
  parameter int SUM_W = 35
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rng_we_i,
  input  logic                                 spt_we_i,
  input  logic [IDX_W-1:0]                     wr_idx_i,
  input  logic [WGT_W-1:0]                     wr_val_i,
  input  logic                                 clear_i,
  input  logic [PIX_W-1:0]                     cen_i,
  input  logic                                 tap_valid_i,
  input  logic [PIX_W-1:0]                     tap_v_i,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]      tap_k_i,
  output logic [NORM_W-1:0]                    norm_o,
  output logic [SUM_W-1:0]                     sum_o,
  output logic                                 busy_o
);
  localparam int SP_W = $clog2(MAX_RADIUS + 1);

  logic [WGT_W-1:0] rng_mem [RANGE_DEPTH];
  logic [WGT_W-1:0] spt_q [MAX_RADIUS+1];

  logic [PIX_W-1:0]        diff;
  logic [WGT_W-1:0]        rng_rd_q;
  logic [PIX_W-1:0]        v2_q, v3_q;
  logic [SP_W-1:0]         k2_q;
  logic                    vld2_q, vld3_q, vld4_q;
  logic [PROD_W-1:0]       w3_q;
  logic [PROD_W+PIX_W-1:0] prod4_q;
  logic [NORM_W-1:0]       norm_q;
  logic [SUM_W-1:0]        sum_q;

  assign diff = (tap_v_i > cen_i) ? tap_v_i - cen_i : cen_i - tap_v_i;

  always_ff @(posedge clk_i) begin
    if (rng_we_i) begin
      rng_mem[wr_idx_i] <= wr_val_i;
    end
    rng_rd_q <= rng_mem[diff];
  end

  always_ff @(posedge clk_i) begin
    if (spt_we_i) begin
      spt_q[SP_W'(wr_idx_i)] <= wr_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld2_q <= tap_valid_i;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    v2_q    <= tap_v_i;
    k2_q    <= tap_k_i;
    w3_q    <= rng_rd_q * spt_q[k2_q];
    v3_q    <= v2_q;
    prod4_q <= w3_q * v3_q;
    if (clear_i) begin
      norm_q <= '0;
      sum_q  <= '0;
    end else begin
      if (vld3_q) begin
        norm_q <= norm_q + NORM_W'(w3_q);
      end
      if (vld4_q) begin
        sum_q <= sum_q + SUM_W'(prod4_q);
      end
    end
  end

  assign norm_o = norm_q;
  assign sum_o  = sum_q;
  assign busy_o = vld2_q | vld3_q | vld4_q;
endmodule

FILE: rtl/sbf_out_fifo.sv
// two-entry result queue in front of the output channel
module sbf_out_fifo
  import sbf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t data_i,
  output logic      full_o,
  sbf_stream_if.source out_o
);
  out_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop           = out_o.valid & out_o.ready;
  assign full_o        = cnt_q == 2'd2;
  assign out_o.valid   = cnt_q != 2'd0;
  assign out_o.payload = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

FILE: bench/tb_separable_bilateral_filter.sv
// self-checking testbench for the separable bilateral filter
module tb_separable_bilateral_filter;
  import sbf_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SRC_ROWS = 9;
  localparam int HOR_ROWS = 17;
  localparam int MAX_W = 2048;
  localparam int MAX_R = 8;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_PHASES = 12;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  sbf_stream_if #(.payload_t(in_item_t)) in_ch ();
  sbf_stream_if #(.payload_t(out_item_t)) out_ch ();

  separable_bilateral_filter dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  // shadow of the block state
  int unsigned range_w[256];
  int unsigned spatial_w[MAX_R+1];
  logic [7:0]  src_rows[SRC_ROWS*MAX_W];
  logic [7:0]  hor_rows[HOR_ROWS*MAX_W];
  int          row_pos;
  int          col_pos;
  int unsigned width_reg;
  int unsigned height_reg;
  int unsigned radius_reg;

  out_item_t exp_results[$];
  dir_row_t  dir_tab[$];
  int        fails;
  int        idle_cycles;
  int        results_seen;
  int        nogap_left;

  int ph_w[N_PHASES] = '{8, 12, 7, 6, 17, 0, 4095, 2048, 1, 10, 20, 9};
  int ph_h[N_PHASES] = '{8, 6, 7, 9, 17, 0, 8191, 1, 4096, 10, 9, 11};
  int ph_r[N_PHASES] = '{1, 2, 3, 3, 8, 0, 15, 1, 2, 2, 3, 2};
  int ph_n[N_PHASES] = '{70, 80, 50, 54, 300, 20, 30, 20, 30, 100, 140, 80};
  bit ph_zero[N_PHASES] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0};

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] bilateral_mean(input int unsigned taps[2*MAX_R+1],
                                                input int r);
    longint unsigned norm, acc, w, q;
    int unsigned c, v, d;
    c = taps[r];
    norm = longint'(range_w[0]) * spatial_w[0];
    acc = norm * c;
    for (int k = 1; k <= r; k++) begin
      for (int side = 0; side < 2; side++) begin
        v = side ? taps[r+k] : taps[r-k];
        d = (v > c) ? v - c : c - v;
        w = longint'(range_w[d & 255]) * spatial_w[k];
        norm += w;
        acc += w * v;
      end
    end
    if (norm == 0) return c[7:0];
    q = (acc + (norm >> 1)) / norm;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic out_item_t make_result(int row, int col, int val);
    out_item_t o;
    o.out_row = row[ROW_W-1:0];
    o.out_col = col[COL_W-1:0];
    o.out_value = val[7:0];
    o.last_of_run = 1'b0;
    return o;
  endfunction

  // updates the shadow state and returns the results one input causes
  function automatic void predict_filter_results(input in_item_t it, ref out_item_t res[$]);
    int w_eff, h_eff, r, x;
    int unsigned taps[2*MAX_R+1];
    res.delete();
    if (it.op == OP_RANGE) begin
      range_w[it.table_index] = it.table_value;
      return;
    end
    if (it.op == OP_SPATIAL) begin
      if (it.table_index <= MAX_R) spatial_w[it.table_index] = it.table_value;
      return;
    end
    if (it.op != OP_PIXEL) return;
    w_eff = (width_reg < 1) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h_eff = (height_reg < 1) ? 1 : (height_reg > 4096) ? 4096 : height_reg;
    r = (radius_reg < 1) ? 1 : (radius_reg > MAX_R) ? MAX_R : radius_reg;
    if (it.frame_start) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (col_pos >= w_eff) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h_eff) row_pos = 0;
    src_rows[(row_pos % SRC_ROWS) * MAX_W + col_pos] = it.pixel;
    if (col_pos >= 2*r && col_pos - r < w_eff - r) begin
      x = col_pos - r;
      for (int i = 0; i <= 2*r; i++)
        taps[i] = src_rows[(row_pos % SRC_ROWS) * MAX_W + col_pos - 2*r + i];
      hor_rows[(row_pos % HOR_ROWS) * MAX_W + x] = bilateral_mean(taps, r);
      if (row_pos >= 2*r && row_pos - r < h_eff - r) begin
        for (int i = 0; i <= 2*r; i++)
          taps[i] = hor_rows[((row_pos - 2*r + i) % HOR_ROWS) * MAX_W + x];
        res.push_back(make_result(row_pos - r, x, bilateral_mean(taps, r)));
      end
    end
    if (row_pos < r || row_pos >= h_eff - r || col_pos < r || col_pos >= w_eff - r)
      res.push_back(make_result(row_pos, col_pos, it.pixel));
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
    col_pos++;
    if (col_pos >= w_eff) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h_eff) row_pos = 0;
    end
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] op, bit fs, int pix, int idx, int val,
                                       bit typed, int row, int col, int v);
    dir_row_t d;
    d.it.op = op;
    d.it.frame_start = fs;
    d.it.pixel = pix[7:0];
    d.it.table_index = idx[7:0];
    d.it.table_value = val[WGT_W-1:0];
    d.typed = typed;
    d.res = make_result(row, col, v);
    d.res.last_of_run = 1'b1;
    return d;
  endfunction

  function automatic int gap_len();
    int p;
    if (nogap_left > 0) begin
      nogap_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p == 0) nogap_left = 30;
    if (p < 40) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res[$];
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_filter_results(it, res);
    if (typed) exp_results.push_back(typed_res);
    else foreach (res[i]) exp_results.push_back(res[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_WIDTH: width_reg = val & 12'hfff;
      REG_HEIGHT: height_reg = val & 13'h1fff;
      default: radius_reg = val & 4'hf;
    endcase
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic in_item_t table_write(logic [1:0] op, int idx, int val);
    in_item_t it;
    it.op = op;
    it.frame_start = 1'($urandom_range(0, 1));
    it.pixel = 8'($urandom_range(0, 255));
    it.table_index = idx[7:0];
    it.table_value = val[WGT_W-1:0];
    return it;
  endfunction

  // stimulus
  initial begin
    in_item_t it;
    out_item_t none;
    int p;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    fails = 0;
    nogap_left = 0;
    none = '0;
    row_pos = 0;
    col_pos = 0;
    width_reg = 2048;
    height_reg = 1024;
    radius_reg = 3;
    foreach (range_w[i]) range_w[i] = 0;
    foreach (spatial_w[i]) spatial_w[i] = 0;

    // defaults after reset: 2048 wide, 1024 high, radius 3, so row 0 passes through
    dir_tab.push_back(dir_row(OP_UNUSED, 1, 255, 255, 2047, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(OP_PIXEL, 0, 0, 0, 0, 1, 0, 0, 0));
    dir_tab.push_back(dir_row(OP_PIXEL, 0, 255, 255, 2047, 1, 0, 1, 255));
    dir_tab.push_back(dir_row(OP_PIXEL, 1, 128, 0, 0, 1, 0, 0, 128));
    dir_tab.push_back(dir_row(OP_UNUSED, 1, 7, 3, 9, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(OP_PIXEL, 0, 1, 0, 0, 1, 0, 1, 1));
    dir_tab.push_back(dir_row(OP_RANGE, 1, 0, 255, 2047, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(OP_RANGE, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(OP_SPATIAL, 0, 0, 8, 2047, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(OP_SPATIAL, 0, 0, 9, 5, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(OP_SPATIAL, 1, 0, 255, 0, 0, 0, 0, 0));
    dir_tab.push_back(dir_row(OP_PIXEL, 0, 8'h55, 0, 0, 1, 0, 2, 8'h55));
    dir_tab.push_back(dir_row(OP_PIXEL, 0, 8'haa, 8'h55, 11'h2aa, 1, 0, 3, 8'haa));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    // fill both weight tables before any filtered pixel can read them
    for (int i = 0; i < 256; i++)
      send_item(table_write(OP_RANGE, i, ($urandom_range(0, 9) == 0) ? 0
                                           : $urandom_range(0, 2047)), 0, none);
    for (int i = 0; i <= MAX_R; i++)
      send_item(table_write(OP_SPATIAL, i, $urandom_range(1, 2047)), 0, none);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_and_settle();
      write_reg(REG_WIDTH, ph_w[ph]);
      write_reg(REG_HEIGHT, ph_h[ph]);
      write_reg(REG_RADIUS, ph_r[ph]);
      // zero weight sum everywhere: every filtered pixel keeps its centre value
      if (ph_zero[ph])
        for (int i = 0; i <= MAX_R; i++) send_item(table_write(OP_SPATIAL, i, 0), 0, none);
      for (int n = 0; n < ph_n[ph]; ) begin
        p = $urandom_range(0, 199);
        if (p < 6) begin
          it = table_write(OP_RANGE, $urandom_range(0, 255), $urandom_range(0, 2047));
        end else if (p < 10 && !ph_zero[ph]) begin
          it = table_write(OP_SPATIAL, $urandom_range(0, 15), $urandom_range(0, 2047));
        end else if (p < 13) begin
          it = table_write(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 2047));
        end else begin
          it.op = OP_PIXEL;
          it.frame_start = (n == 0) || (p == 199);
          it.pixel = 8'($urandom_range(0, 255));
          it.table_index = 8'($urandom_range(0, 255));
          it.table_value = WGT_W'($urandom_range(0, 2047));
          n++;
        end
        send_item(it, 0, none);
      end
      if (ph_zero[ph])
        for (int i = 0; i <= MAX_R; i++)
          send_item(table_write(OP_SPATIAL, i, $urandom_range(1, 2047)), 0, none);
    end

    drain_and_settle();
    if (fails == 0) begin
      $display("separable_bilateral_filter regression: pass");
    end else begin
      $display("separable_bilateral_filter regression: fail");
    end
    $finish;
  end

  // receiver readiness with random stalls and one long hold-off
  initial begin
    bit held;
    int g;
    held = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && results_seen >= 40) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // result check against the oldest expectation
  initial begin
    out_item_t want;
    results_seen = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (exp_results.size() == 0) begin
          fails++;
          $display("%0t unexpected result: actual row %0d col %0d value %0d last %0b",
                   $time, out_ch.payload.out_row, out_ch.payload.out_col,
                   out_ch.payload.out_value, out_ch.payload.last_of_run);
        end else begin
          want = exp_results.pop_front();
          if (out_ch.payload.out_row !== want.out_row) begin
            fails++;
            $display("%0t out_row mismatch: expected %0d actual %0d", $time,
                     want.out_row, out_ch.payload.out_row);
          end
          if (out_ch.payload.out_col !== want.out_col) begin
            fails++;
            $display("%0t out_col mismatch: expected %0d actual %0d", $time,
                     want.out_col, out_ch.payload.out_col);
          end
          if (out_ch.payload.out_value !== want.out_value) begin
            fails++;
            $display("%0t out_value mismatch: expected %0d actual %0d", $time,
                     want.out_value, out_ch.payload.out_value);
          end
          if (out_ch.payload.last_of_run !== want.last_of_run) begin
            fails++;
            $display("%0t last_of_run mismatch: expected %0b actual %0b", $time,
                     want.last_of_run, out_ch.payload.last_of_run);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("separable_bilateral_filter regression: fail");
        $finish;
      end
    end
  end

endmodule

FILE: files.f
rtl/sbf_pkg.sv
rtl/sbf_stream_if.sv
rtl/sbf_div.sv
rtl/sbf_wsum.sv
rtl/sbf_out_fifo.sv
rtl/separable_bilateral_filter.sv
bench/tb_separable_bilateral_filter.sv
